/* rtl/stsd_pkg.sv */
// Shared types, constants and codes for the short-training-sequence frame detector.
`timescale 1ns / 1ps
package stsd_pkg;

    localparam int WINDOW       = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int WIN_BITS     = $clog2(WINDOW);
    localparam int THR_W        = 16;
    localparam int RUN_W        = 8;
    localparam int CFG_W        = 16;
    localparam int DIGIT_W      = 16;

    localparam int PROD_W       = 2 * SAMPLE_BITS + 1;
    localparam int PW_W         = 2 * SAMPLE_BITS;
    localparam int SQ_W         = 2 * SAMPLE_BITS;
    localparam int CORR_W       = PROD_W + WIN_BITS;
    localparam int PWR_W        = PW_W + WIN_BITS;
    localparam int TP_W         = PWR_W + THR_W;
    localparam int TP_DIGITS    = (TP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MAG_DIGITS   = (CORR_W + DIGIT_W - 1) / DIGIT_W;
    localparam int MUL_W        = TP_DIGITS * DIGIT_W;
    localparam int DG_W         = $clog2(TP_DIGITS);
    localparam int LEFT_W       = 2 * CORR_W + 1;
    localparam int RIGHT_W      = 2 * TP_W;
    localparam int CMP_W        = (LEFT_W + 32 > RIGHT_W) ? LEFT_W + 32 : RIGHT_W;

    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd58982;
    localparam logic [RUN_W-1:0] RUN_LENGTH_RESET = 8'd32;

    localparam logic CFG_THRESHOLD  = 1'b0;
    localparam logic CFG_RUN_LENGTH = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef enum logic [1:0] {
        TAG_NONE  = 2'd0,
        TAG_START = 2'd1,
        TAG_END   = 2'd2
    } tag_t;

    typedef struct packed {
        sample_t in_real;
        sample_t in_imag;
    } in_item_t;

    typedef struct packed {
        sample_t    out_real;
        sample_t    out_imag;
        logic [1:0] frame_tag;
    } out_item_t;

    typedef struct packed {
        sample_t x_re;
        sample_t x_im;
        sample_t d_re;
        sample_t d_im;
    } work_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [RUN_W-1:0] run_length;
    } cfg_t;

    typedef struct packed {
        logic push;
        logic full;
    } fifo_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_MAG,
        ST_SQR_R,
        ST_SQR_I,
        ST_TP,
        ST_SQR_TP,
        ST_DECIDE
    } back_state_t;

endpackage

/* rtl/stsd_front.sv */
// Front end: accept samples, pair each with the sample one window back, queue the pair.
`timescale 1ns / 1ps
module stsd_front
    import stsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output fifo_wr_t wr_ctl_unused_guard,
    input  logic     fifo_full,
    output logic     push,
    output work_t    push_data
);

    sample_t              dl_re_reg [WINDOW];
    sample_t              dl_im_reg [WINDOW];
    logic [WIN_BITS-1:0]  pos_reg;
    logic [WIN_BITS-1:0]  pos_next;

    assign in_stall = fifo_full;
    assign push     = in_valid && !fifo_full;

    assign push_data.x_re = in_data.in_real;
    assign push_data.x_im = in_data.in_imag;
    assign push_data.d_re = dl_re_reg[pos_reg];
    assign push_data.d_im = dl_im_reg[pos_reg];

    assign wr_ctl_unused_guard.push = push;
    assign wr_ctl_unused_guard.full = fifo_full;

    // Advance the circular position, wrapping at the window length.
    assign pos_next = (pos_reg == WIN_BITS'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                dl_re_reg[i] <= '0;
                dl_im_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            dl_re_reg[pos_reg] <= in_data.in_real;
            dl_im_reg[pos_reg] <= in_data.in_imag;
            pos_reg            <= pos_next;
        end
    end

endmodule

/* rtl/stsd_fifo.sv */
// Short queue of sample pairs between the front end and the back end.
`timescale 1ns / 1ps
module stsd_fifo
    import stsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fifo_wr_t wr_ctl,
    input  work_t    wr_data,
    input  logic     pop,
    output logic     empty,
    output work_t    rd_data
);

    work_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = wr_ctl.push && !wr_ctl.full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* rtl/stsd_back.sv */
// Back end: moving sums, digit-serial threshold test, plateau run tracking, output register.
`timescale 1ns / 1ps
module stsd_back
    import stsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      empty,
    input  work_t     rd_data,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    back_state_t state_reg, state_next;

    work_t                      w_reg;
    logic signed [SQ_W-1:0]     m_reg [6];
    logic signed [PROD_W-1:0]   hr_reg [WINDOW];
    logic signed [PROD_W-1:0]   hi_reg [WINDOW];
    logic [PW_W-1:0]            hp_reg [WINDOW];
    logic [WIN_BITS-1:0]        pos_reg;
    logic signed [CORR_W-1:0]   cr_reg;
    logic signed [CORR_W-1:0]   ci_reg;
    logic [PWR_W-1:0]           pwr_reg;
    logic [MUL_W-1:0]           op_reg;
    logic [DG_W-1:0]            dg_reg;
    logic [CMP_W-1:0]           acc_l_reg;
    logic [CMP_W-1:0]           acc_r_reg;
    logic [RUN_W-1:0]           run_reg;
    logic                       on_reg;
    logic                       out_valid_reg;
    out_item_t                  out_reg;

    logic signed [PROD_W-1:0]   pr;
    logic signed [PROD_W-1:0]   pi;
    logic [PW_W-1:0]            pw;
    logic [DIGIT_W-1:0]         digit;
    logic [MUL_W+DIGIT_W-1:0]   prod;
    logic [CMP_W-1:0]           prod_sh;
    logic [CORR_W-1:0]          mag_r;
    logic [CORR_W-1:0]          mag_i;
    logic [TP_W-1:0]            tp;
    logic                       above;
    logic                       load_out;
    logic [RUN_W-1:0]           run_inc;
    logic [1:0]                 tag;
    logic                       dg_last_mag;
    logic                       dg_last_tp;

    assign pr = PROD_W'(m_reg[0]) + PROD_W'(m_reg[1]);
    assign pi = PROD_W'(m_reg[2]) - PROD_W'(m_reg[3]);
    assign pw = PW_W'(m_reg[4]) + PW_W'(m_reg[5]);

    assign mag_r = cr_reg[CORR_W-1] ? (~cr_reg + 1'b1) : cr_reg;
    assign mag_i = ci_reg[CORR_W-1] ? (~ci_reg + 1'b1) : ci_reg;
    assign tp    = TP_W'(pwr_reg) * TP_W'(cfg.threshold);

    assign digit   = op_reg[dg_reg * DIGIT_W +: DIGIT_W];
    assign prod    = (MUL_W + DIGIT_W)'(op_reg) * (MUL_W + DIGIT_W)'(digit);
    assign prod_sh = CMP_W'(prod) << {dg_reg, 4'b0000};

    assign dg_last_mag = (dg_reg == DG_W'(MAG_DIGITS - 1));
    assign dg_last_tp  = (dg_reg == DG_W'(TP_DIGITS - 1));

    assign above    = (pwr_reg != '0) && ((acc_l_reg << 32) > acc_r_reg);
    assign load_out = (state_reg == ST_DECIDE) && (!out_valid_reg || !out_stall);
    assign run_inc  = run_reg + 1'b1;

    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        tag = TAG_NONE;
        if (above)
        begin
            if ((run_reg != RUN_MAX) && (run_inc == cfg.run_length))
            begin
                tag = TAG_START;
            end
        end
        else if (on_reg)
        begin
            tag = TAG_END;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (!empty) state_next = ST_MUL;
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_MAG;
            ST_MAG:    state_next = ST_SQR_R;
            ST_SQR_R:  if (dg_last_mag) state_next = ST_SQR_I;
            ST_SQR_I:  if (dg_last_mag) state_next = ST_TP;
            ST_TP:     state_next = ST_SQR_TP;
            ST_SQR_TP: if (dg_last_tp) state_next = ST_DECIDE;
            ST_DECIDE: if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            w_reg <= rd_data;
        end
        if (state_reg == ST_MUL)
        begin
            m_reg[0] <= w_reg.x_re * w_reg.d_re;
            m_reg[1] <= w_reg.x_im * w_reg.d_im;
            m_reg[2] <= w_reg.x_im * w_reg.d_re;
            m_reg[3] <= w_reg.x_re * w_reg.d_im;
            m_reg[4] <= w_reg.x_re * w_reg.x_re;
            m_reg[5] <= w_reg.x_im * w_reg.x_im;
        end
        unique case (state_reg)
            ST_MAG:
            begin
                op_reg    <= MUL_W'(mag_r);
                dg_reg    <= '0;
                acc_l_reg <= '0;
            end
            ST_SQR_R:
            begin
                acc_l_reg <= acc_l_reg + prod_sh;
                dg_reg    <= dg_last_mag ? '0 : dg_reg + 1'b1;
                if (dg_last_mag)
                begin
                    op_reg <= MUL_W'(mag_i);
                end
            end
            ST_SQR_I:
            begin
                acc_l_reg <= acc_l_reg + prod_sh;
                dg_reg    <= dg_last_mag ? '0 : dg_reg + 1'b1;
            end
            ST_TP:
            begin
                op_reg    <= MUL_W'(tp);
                dg_reg    <= '0;
                acc_r_reg <= '0;
            end
            ST_SQR_TP:
            begin
                acc_r_reg <= acc_r_reg + prod_sh;
                dg_reg    <= dg_last_tp ? '0 : dg_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_reg.out_real  <= w_reg.x_re;
            out_reg.out_imag  <= w_reg.x_im;
            out_reg.frame_tag <= tag;
        end
    end

    // Moving sums, histories and run tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cr_reg        <= '0;
            ci_reg        <= '0;
            pwr_reg       <= '0;
            run_reg       <= '0;
            on_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                hr_reg[i] <= '0;
                hi_reg[i] <= '0;
                hp_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_SUM)
            begin
                cr_reg  <= cr_reg + CORR_W'(pr) - CORR_W'(hr_reg[pos_reg]);
                ci_reg  <= ci_reg + CORR_W'(pi) - CORR_W'(hi_reg[pos_reg]);
                pwr_reg <= pwr_reg + PWR_W'(pw) - PWR_W'(hp_reg[pos_reg]);
                hr_reg[pos_reg] <= pr;
                hi_reg[pos_reg] <= pi;
                hp_reg[pos_reg] <= pw;
                pos_reg <= (pos_reg == WIN_BITS'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (above)
                begin
                    if (run_reg != RUN_MAX)
                    begin
                        run_reg <= run_inc;
                        if (run_inc == cfg.run_length)
                        begin
                            on_reg <= 1'b1;
                        end
                    end
                end
                else
                begin
                    run_reg <= '0;
                    on_reg  <= 1'b0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_tag_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.frame_tag != 2'd3))
        else $error("frame tag holds an unused code");

    a_end_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (tag == TAG_END)) |=> (run_reg == '0) && !on_reg)
        else $error("end tag did not clear the run");

    a_start_sets_plateau: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (tag == TAG_START)) |=> on_reg && out_valid_reg)
        else $error("start tag did not mark the plateau");

endmodule

/* rtl/sts_autocorrelation_frame_detector_unit.sv */
// Top level of the short-training-sequence frame detector: config registers and wiring.
// The back end takes one sample at a time from the queue and squares both correlation
//   sums and the scaled power for it on a digit-serial 64x16 multiplier; meanwhile the
//   front end keeps accepting samples into the queue until the queue is full.
// Reset (rst_n, asynchronous, active low) zeroes the delay line, histories, sums and run
//   count, clears the queue and output, and loads the register reset values.
`timescale 1ns / 1ps
module sts_autocorrelation_frame_detector_unit
    import stsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    cfg_t     cfg_reg;
    fifo_wr_t wr_ctl;
    logic     fifo_full;
    logic     push;
    work_t    push_data;
    logic     pop;
    logic     fifo_empty;
    work_t    rd_data;

    // Configuration writes land here; both registers feed the back end directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold  <= THRESHOLD_RESET;
            cfg_reg.run_length <= RUN_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:  cfg_reg.threshold  <= cfg_wdata[THR_W-1:0];
                CFG_RUN_LENGTH: cfg_reg.run_length <= cfg_wdata[RUN_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // The queue is full when it holds its depth; the back end pops it one pair at a time.
    stsd_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .in_data             (in_data),
        .wr_ctl_unused_guard (wr_ctl),
        .fifo_full           (fifo_full),
        .push                (push),
        .push_data           (push_data)
    );

    stsd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_ctl  (wr_ctl),
        .wr_data (push_data),
        .pop     (pop),
        .empty   (fifo_empty),
        .rd_data (rd_data)
    );

    stsd_fifo_level u_level (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop && !fifo_empty),
        .full  (fifo_full)
    );

    stsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (fifo_empty),
        .rd_data   (rd_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// Fill level tracker that flags the queue as full.
module stsd_fifo_level
    import stsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic pop,
    output logic full
);

    logic [FIFO_CNT_W-1:0] level_reg;

    assign full = (level_reg == FIFO_CNT_W'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            unique case ({push, pop})
                2'b10:   level_reg <= level_reg + 1'b1;
                2'b01:   level_reg <= level_reg - 1'b1;
                default: level_reg <= level_reg;
            endcase
        end
    end

endmodule

/* dv/sts_autocorrelation_frame_detector_unit_test.sv */
// Self-checking testbench for the short-training-sequence frame detector.
`timescale 1ns / 1ps
module sts_autocorrelation_frame_detector_unit_test;
    import stsd_pkg::*;

    // Predicts the pass-through sample and frame tag of every accepted sample
    // and holds those predictions until the block delivers them.
    class frame_tag_scoreboard;
        logic [THR_W-1:0] threshold;
        logic [RUN_W-1:0] run_length;
        longint delay_re[WINDOW];
        longint delay_im[WINDOW];
        longint prod_re[WINDOW];
        longint prod_im[WINDOW];
        longint pow_hist[WINDOW];
        longint corr_re, corr_im, pow_sum;
        logic [RUN_W-1:0] run_count;
        bit on_plateau;
        int wr_pos;
        out_item_t expected_outputs[$];
        int errors;

        function new();
            threshold  = THRESHOLD_RESET;
            run_length = RUN_LENGTH_RESET;
            foreach (delay_re[k])
            begin
                delay_re[k] = 0; delay_im[k] = 0;
                prod_re[k] = 0; prod_im[k] = 0; pow_hist[k] = 0;
            end
            corr_re = 0; corr_im = 0; pow_sum = 0;
            run_count = 0; on_plateau = 0; wr_pos = 0; errors = 0;
        endfunction

        function void write_register(logic idx, logic [CFG_W-1:0] val);
            if (idx == CFG_THRESHOLD)
                threshold = val[THR_W-1:0];
            else
                run_length = val[RUN_W-1:0];
        endfunction

        // |C|^2 * 2^32 > (thr * P)^2, with zero power never on the plateau
        function bit correlation_high();
            logic [127:0] mr, mi, lhs, tp, rhs;
            if (pow_sum <= 0)
                return 0;
            mr  = (corr_re < 0) ? -corr_re : corr_re;
            mi  = (corr_im < 0) ? -corr_im : corr_im;
            lhs = (mr * mr + mi * mi) << 32;
            tp  = 128'(pow_sum) * 128'(threshold);
            rhs = tp * tp;
            return lhs > rhs;
        endfunction

        function void note_sample(in_item_t s);
            longint xr, xi, dr, di, pr, pi, pw;
            out_item_t o;
            xr = longint'(s.in_real);
            xi = longint'(s.in_imag);
            dr = delay_re[wr_pos];
            di = delay_im[wr_pos];
            pr = xr * dr + xi * di;
            pi = xi * dr - xr * di;
            pw = xr * xr + xi * xi;
            delay_re[wr_pos] = xr;
            delay_im[wr_pos] = xi;
            corr_re += pr - prod_re[wr_pos];
            corr_im += pi - prod_im[wr_pos];
            pow_sum += pw - pow_hist[wr_pos];
            prod_re[wr_pos] = pr;
            prod_im[wr_pos] = pi;
            pow_hist[wr_pos] = pw;
            wr_pos = (wr_pos + 1) % WINDOW;
            o.out_real  = s.in_real;
            o.out_imag  = s.in_imag;
            o.frame_tag = TAG_NONE;
            if (correlation_high())
            begin
                // a saturated counter stays put and cannot re-tag
                if (run_count != RUN_MAX)
                begin
                    run_count++;
                    if (run_count == run_length)
                    begin
                        o.frame_tag = TAG_START;
                        on_plateau = 1;
                    end
                end
            end
            else
            begin
                if (on_plateau)
                    o.frame_tag = TAG_END;
                on_plateau = 0;
                run_count = 0;
            end
            expected_outputs.push_back(o);
        endfunction

        function void check_output(out_item_t got);
            out_item_t want;
            if (expected_outputs.size() == 0)
            begin
                $display("%0t: unexpected output %h", $time, got);
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            if (got.out_real !== want.out_real)
            begin
                $display("%0t: out_real expected %0d actual %0d", $time,
                         want.out_real, got.out_real);
                errors++;
            end
            if (got.out_imag !== want.out_imag)
            begin
                $display("%0t: out_imag expected %0d actual %0d", $time,
                         want.out_imag, got.out_imag);
                errors++;
            end
            if (got.frame_tag !== want.frame_tag)
            begin
                $display("%0t: frame_tag expected %0d actual %0d", $time,
                         want.frame_tag, got.frame_tag);
                errors++;
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 40;

    // idling styles, one per phase
    localparam int IDLE_NONE     = 0;
    localparam int IDLE_SENDER   = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH     = 3;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    frame_tag_scoreboard sb;
    int idle_mode;
    int cycle_count;
    sample_t sts_re[WINDOW];
    sample_t sts_im[WINDOW];

    sts_autocorrelation_frame_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sts_autocorrelation_frame_detector_unit_test: errors");
            $finish;
        end
    end

    // Receiver: check every transfer, then choose the stall for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_output(out_data);
        case (idle_mode)
            IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 74);
            IDLE_BOTH:     out_stall <= ($urandom_range(99) < 12);
            default:       out_stall <= 1'b0;
        endcase
    end

    function bit sender_rests();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(99) < 74;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 12;
        return 0;
    endfunction

    // Present one sample and hold it until the block takes the transfer.
    task automatic send_sample(sample_t re, sample_t im);
        in_item_t s;
        s.in_real = re;
        s.in_imag = im;
        while (sender_rests())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_sample(s);
    endtask

    // Drop valid and wait until every predicted output has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Pulse the write enable for one edge, then leave a quiet edge after it.
    task automatic write_register(logic idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_register(idx, val);
        @(posedge clk);
    endtask

    // A periodic training-like burst: one random window repeated, so the
    // delayed correlation locks on; full-scale or small amplitude at random.
    task automatic send_training_burst(int len);
        int amp_bits;
        amp_bits = $urandom_range(1) ? 16 : $urandom_range(12, 2);
        for (int k = 0; k < WINDOW; k++)
        begin
            sts_re[k] = sample_t'($signed($urandom) >>> (32 - amp_bits));
            sts_im[k] = sample_t'($signed($urandom) >>> (32 - amp_bits));
        end
        for (int k = 0; k < len; k++)
            send_sample(sts_re[k % WINDOW], sts_im[k % WINDOW]);
    endtask

    task automatic send_noise(int len);
        for (int k = 0; k < len; k++)
            send_sample(sample_t'($urandom), sample_t'($urandom));
    endtask

    task automatic run_phase(int items, bit hold_off);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(99) < 75)
            begin
                // now and then a long one, to drive the run counter to saturation
                len = ($urandom_range(9) == 0) ? $urandom_range(300, 270)
                                               : $urandom_range(120, 20);
                send_training_burst(len);
            end
            else
            begin
                len = $urandom_range(30, 1);
                send_noise(len);
            end
            sent += len;
            // hold the sender until the block has caught up
            if (hold_off && sent > items / 2)
            begin
                drain();
                hold_off = 0;
            end
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] thr_set[8];
        logic [CFG_W-1:0] run_set[8];

        sb = new();
        cycle_count = 0;
        idle_mode = IDLE_NONE;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, zero power, single-bit and checker patterns.
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(-16'sh8000, -16'sh8000);
        send_sample(16'sh7fff, -16'sh8000);
        send_sample(-16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0001, -16'sh0001);
        send_sample(16'sh5555, -16'sh5556);
        send_sample(-16'sh5556, 16'sh5555);
        // a full window of silence empties the sums: zero power
        for (int k = 0; k < WINDOW + 1; k++)
            send_sample(16'sh0000, 16'sh0000);
        drain();

        // Register sets: defaults, both threshold extremes, shortest and longest
        // runs, a run length of zero, and a write wider than the run register.
        thr_set = '{16'd58982, 16'd0, 16'hffff, 16'd32768,
                    16'd0, 16'd50000, 16'hffff, 16'd20000};
        run_set = '{16'd32, 16'd1, 16'd255, 16'd0,
                    16'd255, 16'h0104, 16'd1, 16'd16};
        for (int p = 0; p < 8; p++)
        begin
            idle_mode = p % 4;
            if (p == 7)
            begin
                thr_set[p] = 16'($urandom);
                run_set[p] = 16'($urandom_range(64, 1));
            end
            write_register(CFG_THRESHOLD, thr_set[p]);
            write_register(CFG_RUN_LENGTH, run_set[p]);
            run_phase(100, p == 1 || p == 6);
            drain();
        end

        // A register change in the middle of a plateau can tag a start again.
        idle_mode = IDLE_NONE;
        write_register(CFG_THRESHOLD, 16'd0);
        write_register(CFG_RUN_LENGTH, 16'd8);
        send_training_burst(40);
        drain();
        write_register(CFG_RUN_LENGTH, 16'd20);
        send_training_burst(60);
        drain();

        if (sb.errors == 0)
            $display("sts_autocorrelation_frame_detector_unit_test: clean");
        else
            $display("sts_autocorrelation_frame_detector_unit_test: errors");
        $finish;
    end

endmodule

/* sts_autocorrelation_frame_detector_unit.f */
rtl/stsd_pkg.sv
rtl/stsd_front.sv
rtl/stsd_fifo.sv
rtl/stsd_back.sv
rtl/sts_autocorrelation_frame_detector_unit.sv
dv/sts_autocorrelation_frame_detector_unit_test.sv
